>>> hdl/dam_pkg.sv
// shared types and constants for the diagonal associative memory
`default_nettype none
package dam_pkg;
  localparam int unsigned SIZE_DEF  = 16;
  localparam int unsigned V_BITS    = 3;
  localparam int unsigned AB_BITS   = 4;
  localparam int unsigned S_BITS    = 5;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_RD_WORD = 4'd0,
    OP_WR_WORD = 4'd1,
    OP_RD_DIAG = 4'd2,
    OP_WR_DIAG = 4'd3,
    OP_OR      = 4'd4,
    OP_NOR     = 4'd5,
    OP_COPY    = 4'd6,
    OP_NOT     = 4'd7,
    OP_KEY_SUM = 4'd8,
    OP_NEAREST = 4'd9
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  row_start;
    logic [3:0]  column;
    logic [3:0]  second_column;
    logic [3:0]  dest_column;
    logic [15:0] data;
    logic [15:0] key;
    logic [4:0]  key_length;
  } cmd_t;

  typedef struct packed {
    logic        strobe;
    logic [15:0] read_data;
    logic        any_match;
    logic        below_found;
    logic [3:0]  below_index;
    logic [15:0] below_val;
    logic        above_found;
    logic [3:0]  above_index;
    logic [15:0] above_val;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } bst_t;
endpackage
`default_nettype wire

>>> hdl/dam_front.sv
// front end: takes commands, clips key length, queues them for the back end
`default_nettype none
module dam_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [3:0]    in_operation,
  input  wire logic [3:0]    in_row_start,
  input  wire logic [3:0]    in_column,
  input  wire logic [3:0]    in_second_column,
  input  wire logic [3:0]    in_dest_column,
  input  wire logic [15:0]   in_data,
  input  wire logic [15:0]   in_key,
  input  wire logic [4:0]    in_key_length,
  input  wire logic          pop,
  output logic               q_valid,
  output dam_pkg::cmd_t      q_cmd
);
  import dam_pkg::*;

  cmd_t       mem_r [FIFO_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push;

  always_comb begin
    c = '0;
    c.op            = in_operation;
    c.row_start     = in_row_start;
    c.column        = in_column;
    c.second_column = in_second_column;
    c.dest_column   = in_dest_column;
    c.data          = in_data;
    c.key           = in_key;
    c.key_length    = (in_key_length > 5'd16) ? 5'd16 : in_key_length;
  end

  assign busy    = (cnt_r == 2'(FIFO_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hdl/dam_back.sv
// back end: bit matrix and the operation sequencer
`default_nettype none
module dam_back #(
  parameter int unsigned SIZE = dam_pkg::SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  dam_pkg::cmd_t      q_cmd,
  output logic               pop,
  output dam_pkg::res_t      res
);
  import dam_pkg::*;
  localparam int unsigned IW = $clog2(SIZE);

  logic [SIZE-1:0] mat_r [SIZE];
  bst_t            st_r, st_nxt;
  cmd_t            cmd_r;
  logic [IW-1:0]   k_r;
  logic            bf_r, af_r, match_r;
  logic [IW-1:0]   bi_r, ai_r;
  logic [SIZE-1:0] bw_r, aw_r;
  res_t            res_r;

  // word k gathered from the matrix (row k+i, column k)
  function automatic logic [SIZE-1:0] word_at(input logic [IW-1:0] k,
                                              input logic [SIZE-1:0] m [SIZE]);
    logic [SIZE-1:0] w;
    logic [IW-1:0]   r;
    w = '0;
    for (int i = 0; i < SIZE; i++) begin
      r = k + IW'(i);
      w[SIZE-1-i] = m[r][k];
    end
    return w;
  endfunction

  logic [SIZE-1:0] wk, wide, wa, wb, rseq, lres;
  logic [15:0]     w16, nw16;
  logic [15:0]     kmask;
  logic [15:0]     rd16;
  logic            kmatch;
  logic [IW-1:0]   c1, c2, rs;

  always_comb begin
    c1   = IW'(cmd_r.column);
    c2   = IW'(cmd_r.second_column);
    rs   = IW'(cmd_r.row_start);
    wide = '0;
    wide[SIZE-1 -: 16] = cmd_r.data;
    wk   = word_at(k_r, mat_r);
    wa   = word_at(c1, mat_r);
    wb   = word_at(c2, mat_r);
    rseq = '0;
    for (int i = 0; i < SIZE; i++) begin
      rseq[SIZE-1-i] = (cmd_r.op == OP_RD_DIAG) ?
        mat_r[rs + IW'(i)][c1 + IW'(i)] : mat_r[rs + IW'(i)][c1];
    end
    case (cmd_r.op)
      OP_OR:   lres = wa | wb;
      OP_NOR:  lres = ~(wa | wb);
      OP_COPY: lres = wa;
      default: lres = ~wa;
    endcase
    case (cmd_r.op)
      OP_RD_WORD, OP_RD_DIAG:         rd16 = rseq[SIZE-1 -: 16];
      OP_OR, OP_NOR, OP_COPY, OP_NOT: rd16 = lres[SIZE-1 -: 16];
      default:                        rd16 = 16'd0;
    endcase
    w16   = wk[SIZE-1 -: 16];
    kmask = ~(16'hffff >> cmd_r.key_length);
    kmatch = ((w16 ^ cmd_r.key) & kmask) == 16'd0;
    nw16  = {w16[15:S_BITS],
             5'({1'b0, w16[15-V_BITS -: AB_BITS]} + {1'b0, w16[15-V_BITS-AB_BITS -: AB_BITS]})};
  end

  always_comb begin
    st_nxt = st_r;
    pop    = 1'b0;
    case (st_r)
      ST_IDLE: if (q_valid) begin pop = 1'b1; st_nxt = ST_EXEC; end
      ST_EXEC: begin
        if (cmd_r.op == OP_KEY_SUM || cmd_r.op == OP_NEAREST) st_nxt = ST_SCAN;
        else st_nxt = ST_DONE;
      end
      ST_SCAN: if (k_r == IW'(SIZE-1)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SIZE; r++) mat_r[r] <= '0;
      res_r.strobe <= 1'b0;
    end else begin
      res_r.strobe <= 1'b0;
      if (pop) cmd_r <= q_cmd;
      case (st_r)
        ST_EXEC: begin
          k_r <= '0; bf_r <= 1'b0; af_r <= 1'b0; match_r <= 1'b0;
          bi_r <= '0; ai_r <= '0; bw_r <= '0; aw_r <= '0;
          res_r.read_data <= rd16;
          case (cmd_r.op)
            OP_WR_WORD: for (int i = 0; i < 16; i++)
              mat_r[rs + IW'(i)][c1] <= cmd_r.data[15-i];
            OP_WR_DIAG: for (int i = 0; i < 16; i++)
              mat_r[rs + IW'(i)][c1 + IW'(i)] <= cmd_r.data[15-i];
            OP_OR, OP_NOR, OP_COPY, OP_NOT: begin
              for (int i = 0; i < SIZE; i++)
                mat_r[IW'(cmd_r.dest_column) + IW'(i)][IW'(cmd_r.dest_column)]
                  <= lres[SIZE-1-i];
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          k_r <= k_r + IW'(1);
          if (cmd_r.op == OP_KEY_SUM) begin
            if (kmatch) begin
              match_r <= 1'b1;
              for (int i = 0; i < SIZE; i++)
                mat_r[k_r + IW'(i)][k_r] <= (i < 16) ? nw16[15-i] : 1'b0;
            end
          end else begin
            if (wk < wide && (!bf_r || wk > bw_r)) begin
              bf_r <= 1'b1; bi_r <= k_r; bw_r <= wk;
            end else if (wk > wide && (!af_r || wk < aw_r)) begin
              af_r <= 1'b1; ai_r <= k_r; aw_r <= wk;
            end
          end
        end
        ST_DONE: begin
          res_r.strobe      <= 1'b1;
          res_r.any_match   <= match_r;
          res_r.below_found <= bf_r;
          res_r.below_index <= 4'(bi_r);
          res_r.below_val   <= bw_r[SIZE-1 -: 16];
          res_r.above_found <= af_r;
          res_r.above_index <= 4'(ai_r);
          res_r.above_val   <= aw_r[SIZE-1 -: 16];
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

>>> hdl/diagonal_associative_memory.sv
// top level of the diagonal associative memory
`default_nettype none
// A SIZE x SIZE bit matrix holding SIZE words on wrapped diagonals; SIZE is
// taken as a power of two so row and column indices wrap on their bit width.
// A transaction is taken when start is high and busy is low; a two-entry
// command queue lets the next transaction in while one executes, and busy
// rises only when that queue is full. Each transaction yields one result,
// shown for exactly one cycle with out_valid high; the receiver cannot stall
// it. Word and diagonal accesses and logic operations step the back end
// through its IDLE, EXEC and DONE states; key sum and nearest search add a
// SCAN state that walks the SIZE words one per cycle. The back end pops the
// next queued command only once it is back in IDLE.
module diagonal_associative_memory #(
  parameter int unsigned SIZE = dam_pkg::SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_operation,
  input  wire logic [3:0]  in_row_start,
  input  wire logic [3:0]  in_column,
  input  wire logic [3:0]  in_second_column,
  input  wire logic [3:0]  in_dest_column,
  input  wire logic [15:0] in_data,
  input  wire logic [15:0] in_key,
  input  wire logic [4:0]  in_key_length,
  output logic             out_valid,
  output logic [15:0]      out_read_data,
  output logic             out_any_match,
  output logic             out_below_found,
  output logic [3:0]       out_below_index,
  output logic [15:0]      out_below_val,
  output logic             out_above_found,
  output logic [3:0]       out_above_index,
  output logic [15:0]      out_above_val
);
  import dam_pkg::*;

  // queue between front and back
  logic q_valid, pop;
  cmd_t q_cmd;
  res_t res;

  dam_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_row_start, .in_column, .in_second_column,
    .in_dest_column, .in_data, .in_key, .in_key_length,
    .pop, .q_valid, .q_cmd
  );

  // sequencer owns the matrix
  dam_back #(.SIZE(SIZE)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .pop, .res
  );

  assign out_valid       = res.strobe;
  assign out_read_data   = res.read_data;
  assign out_any_match   = res.any_match;
  assign out_below_found = res.below_found;
  assign out_below_index = res.below_index;
  assign out_below_val   = res.below_val;
  assign out_above_found = res.above_found;
  assign out_above_index = res.above_index;
  assign out_above_val   = res.above_val;
endmodule
`default_nettype wire

>>> hdl/dam_checker.sv
// port-level assertions for the diagonal associative memory
`default_nettype none
module dam_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_below_found,
  input wire logic [3:0]  out_below_index,
  input wire logic [15:0] out_below_val,
  input wire logic        out_above_found,
  input wire logic [15:0] out_above_val
);
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy) else $error("activity after reset");
  a_below_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_below_found |-> out_below_index == 4'd0 && out_below_val == 16'd0)
    else $error("below fields without find");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_below_found && out_above_found |-> out_below_val < out_above_val)
    else $error("below not under above");
endmodule

bind diagonal_associative_memory dam_checker u_chk (
  .clk, .rst_n, .busy, .out_valid, .out_below_found, .out_below_index,
  .out_below_val, .out_above_found, .out_above_val
);
`default_nettype wire
